// ===== rtl/pbkdf2_pkg.sv =====
// Shared types, constants and SHA-256 helper functions for the key derivation block.
package pbkdf2_pkg;

    typedef logic [7:0][31:0] digest_t;

    typedef struct packed {
        logic        command;
        logic [7:0]  password_byte;
        logic [63:0] salt_high;
        logic [63:0] salt_low;
    } in_t;

    typedef struct packed {
        logic [63:0] key_word;
        logic [1:0]  word_index;
        logic        last_word;
        logic        status;
    } out_t;

    localparam logic       CMD_APPEND     = 1'b0;
    localparam logic       CMD_START      = 1'b1;
    localparam logic [1:0] LAST_WORD_IDX  = 2'd3;
    localparam logic [7:0] IPAD_BYTE      = 8'h36;
    localparam logic [7:0] OPAD_BYTE      = 8'h5c;
    localparam int         BLOCK_BYTES    = 64;
    localparam int         COUNT_W        = 21;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 21'd210000;

    localparam digest_t SHA_IV = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_s0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_s0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_s1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // 32-byte message after a 64-byte key block: pad and length 768 bits
    function automatic logic [511:0] digest_block(input digest_t d);
        return {d[0], d[1], d[2], d[3], d[4], d[5], d[6], d[7],
                32'h80000000, 192'd0, 32'd768};
    endfunction

    // salt || 00000001 after a 64-byte key block: length 672 bits
    function automatic logic [511:0] salt_block(input logic [127:0] s);
        return {s, 32'h00000001, 32'h80000000, 288'd0, 32'd672};
    endfunction

endpackage

// ===== rtl/pbkdf2_hmac_sha256_key_derive.sv =====
// PBKDF2-HMAC-SHA256 key derivation: one shared SHA-256 round unit under a sequencer.
// Start request: every compression runs 64 rounds, then adds the chaining value; blocks
// read from the password RAM are first loaded into the window byte by byte.
// Setup is 2 such loaded compressions (password up to 64 bytes) plus 2 to 3
// more to hash a longer key, then each iteration is two compressions, then 4 output words.
// Reset (async, active low) empties the password, clears the overflow flag, sets the
// iteration count to 210000 and returns the sequencer to idle; RAM contents stay undefined.
module pbkdf2_hmac_sha256_key_derive #(
    parameter int MAX_PASSWORD_BYTES = 128
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  pbkdf2_pkg::in_t             in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output pbkdf2_pkg::out_t            out_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [pbkdf2_pkg::COUNT_W-1:0] cfg_data
);

    // Widths that follow from the password capacity
    localparam int AW      = (MAX_PASSWORD_BYTES > 1) ? $clog2(MAX_PASSWORD_BYTES) : 1;
    localparam int LW      = $clog2(MAX_PASSWORD_BYTES + 1);
    localparam int BLK_MAX = (MAX_PASSWORD_BYTES + 72) / 64;
    localparam int BW      = $clog2(BLK_MAX + 1);
    localparam int PW      = (BW + 6 > LW) ? BW + 6 : LW;
    localparam int CW      = pbkdf2_pkg::COUNT_W;

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_FINAL = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    // Which compression is in flight
    localparam logic [2:0] PH_KHASH = 3'd0;
    localparam logic [2:0] PH_IPAD  = 3'd1;
    localparam logic [2:0] PH_OPAD  = 3'd2;
    localparam logic [2:0] PH_INNER = 3'd3;
    localparam logic [2:0] PH_OUTER = 3'd4;

    localparam logic [6:0] LOAD_END   = 7'(pbkdf2_pkg::BLOCK_BYTES);
    localparam logic [5:0] LAST_ROUND = 6'd63;

    // Control state
    logic [2:0]    state_reg, state_next;
    logic [2:0]    phase_reg, phase_next;
    logic [BW-1:0] blk_reg, blk_next;
    logic [6:0]    bc_reg, bc_next;
    logic          ld_valid_reg, ld_valid_next;
    logic [5:0]    pos_reg, pos_next;
    logic [5:0]    rc_reg, rc_next;
    logic [LW-1:0] len_reg, len_next;
    logic          ovf_reg, ovf_next;
    logic          hashed_reg, hashed_next;
    logic          first_reg, first_next;
    logic [CW-1:0] it_reg, it_next;
    logic [CW-1:0] iter_reg, iter_next;
    logic [1:0]    word_reg, word_next;

    // Datapath
    logic [511:0]        win_reg, win_next;
    pbkdf2_pkg::digest_t v_reg, v_next;
    pbkdf2_pkg::digest_t hc_reg, hc_next;
    pbkdf2_pkg::digest_t dig_reg, dig_next;
    pbkdf2_pkg::digest_t ipad_reg, ipad_next;
    pbkdf2_pkg::digest_t opad_reg, opad_next;
    pbkdf2_pkg::digest_t acc_reg, acc_next;
    logic [127:0]        salt_reg, salt_next;

    logic                in_fire;
    logic                cfg_fire;
    logic                ram_we;
    logic [AW-1:0]       ram_rd_addr;
    logic [7:0]          ram_rd_data;

    logic [31:0]         w0, w1, w9, w14, w_new;
    logic [31:0]         t1, t2;
    pbkdf2_pkg::digest_t v_round;
    pbkdf2_pkg::digest_t sum;

    logic [PW-1:0]       pos_full;
    logic [PW-1:0]       len_full;
    logic [PW:0]         last_sum;
    logic [BW-1:0]       last_blk;
    logic [15:0]         len_bits;
    logic [31:0]         key_word32;
    logic [7:0]          key_byte;
    logic [7:0]          load_byte;
    logic [CW-1:0]       it_inc;
    logic [CW-1:0]       count_eff;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid & in_ready;
    assign cfg_fire  = cfg_valid & cfg_ready;

    // Store a password byte while room remains
    assign ram_we      = in_fire && (in_data.command == pbkdf2_pkg::CMD_APPEND)
                         && (32'(len_reg) < 32'(MAX_PASSWORD_BYTES));
    assign ram_rd_addr = AW'({blk_reg, bc_reg[5:0]});

    pbkdf2_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PASSWORD_BYTES)
    ) u_password_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (AW'(len_reg)),
        .wr_data (in_data.password_byte),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Shared round unit: window word 0 is W[t], the appended word is W[t+16]
    assign w0  = win_reg[511 -: 32];
    assign w1  = win_reg[479 -: 32];
    assign w9  = win_reg[223 -: 32];
    assign w14 = win_reg[63 -: 32];
    assign w_new = w0 + pbkdf2_pkg::small_s0(w1) + w9 + pbkdf2_pkg::small_s1(w14);

    assign t1 = v_reg[7] + pbkdf2_pkg::big_s1(v_reg[4])
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + pbkdf2_pkg::K_TABLE[rc_reg] + w0;
    assign t2 = pbkdf2_pkg::big_s0(v_reg[0])
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    always_comb
    begin
        v_round[0] = t1 + t2;
        v_round[1] = v_reg[0];
        v_round[2] = v_reg[1];
        v_round[3] = v_reg[2];
        v_round[4] = v_reg[3] + t1;
        v_round[5] = v_reg[4];
        v_round[6] = v_reg[5];
        v_round[7] = v_reg[6];
        for (int i = 0; i < 8; i++)
        begin
            sum[i] = hc_reg[i] + v_reg[i];
        end
    end

    // Byte fed into the window while a block is loaded, from the password RAM or the hashed key
    assign pos_full   = PW'({blk_reg, pos_reg});
    assign len_full   = PW'(len_reg);
    assign last_sum   = (PW + 1)'(len_reg) + (PW + 1)'(8);
    assign last_blk   = BW'(last_sum >> 6);
    assign len_bits   = 16'({len_reg, 3'b000});
    assign key_word32 = dig_reg[pos_reg[4:2]];

    always_comb
    begin
        key_byte  = 8'h00;
        load_byte = 8'h00;
        if (phase_reg == PH_KHASH)
        begin
            if (pos_full < len_full)
            begin
                load_byte = ram_rd_data;
            end
            else if (pos_full == len_full)
            begin
                load_byte = 8'h80;
            end
            else if (blk_reg == last_blk && pos_reg == 6'd62)
            begin
                load_byte = len_bits[15:8];
            end
            else if (blk_reg == last_blk && pos_reg == 6'd63)
            begin
                load_byte = len_bits[7:0];
            end
        end
        else
        begin
            if (hashed_reg)
            begin
                key_byte = pos_reg[5] ? 8'h00 : key_word32[{~pos_reg[1:0], 3'b000} +: 8];
            end
            else if (pos_full < len_full)
            begin
                key_byte = ram_rd_data;
            end
            load_byte = key_byte ^ ((phase_reg == PH_IPAD) ? pbkdf2_pkg::IPAD_BYTE
                                                           : pbkdf2_pkg::OPAD_BYTE);
        end
    end

    // A zero count runs one iteration
    assign count_eff = (iter_reg == '0) ? CW'(1) : iter_reg;
    assign it_inc    = it_reg + CW'(1);

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        blk_next      = blk_reg;
        bc_next       = bc_reg;
        ld_valid_next = 1'b0;
        pos_next      = bc_reg[5:0];
        rc_next       = rc_reg;
        len_next      = len_reg;
        ovf_next      = ovf_reg;
        hashed_next   = hashed_reg;
        first_next    = first_reg;
        it_next       = it_reg;
        iter_next     = cfg_fire ? cfg_data : iter_reg;
        word_next     = word_reg;
        win_next      = win_reg;
        v_next        = v_reg;
        hc_next       = hc_reg;
        dig_next      = dig_reg;
        ipad_next     = ipad_reg;
        opad_next     = opad_reg;
        acc_next      = acc_reg;
        salt_next     = salt_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_data.command == pbkdf2_pkg::CMD_APPEND)
                    begin
                        if (ram_we)
                        begin
                            len_next = len_reg + LW'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    else
                    begin
                        // Start: hash an over-long key first, else go straight to the pads
                        salt_next   = {in_data.salt_high, in_data.salt_low};
                        hashed_next = 32'(len_reg) > 32'(pbkdf2_pkg::BLOCK_BYTES);
                        phase_next  = (32'(len_reg) > 32'(pbkdf2_pkg::BLOCK_BYTES))
                                      ? PH_KHASH : PH_IPAD;
                        blk_next    = '0;
                        bc_next     = '0;
                        hc_next     = pbkdf2_pkg::SHA_IV;
                        it_next     = '0;
                        first_next  = 1'b1;
                        state_next  = ST_LOAD;
                    end
                end
            end

            ST_LOAD:
            begin
                if (bc_reg != LOAD_END)
                begin
                    bc_next       = bc_reg + 7'd1;
                    ld_valid_next = 1'b1;
                end
                if (ld_valid_reg)
                begin
                    win_next = {win_reg[503:0], load_byte};
                end
                if (ld_valid_reg && bc_reg == LOAD_END)
                begin
                    v_next     = hc_reg;
                    rc_next    = '0;
                    state_next = ST_ROUND;
                end
            end

            ST_ROUND:
            begin
                v_next   = v_round;
                win_next = {win_reg[479:0], w_new};
                rc_next  = rc_reg + 6'd1;
                if (rc_reg == LAST_ROUND)
                begin
                    state_next = ST_FINAL;
                end
            end

            ST_FINAL:
            begin
                hc_next = sum;
                unique case (phase_reg)
                    PH_KHASH:
                    begin
                        bc_next    = '0;
                        state_next = ST_LOAD;
                        if (blk_reg == last_blk)
                        begin
                            dig_next   = sum;
                            hc_next    = pbkdf2_pkg::SHA_IV;
                            blk_next   = '0;
                            phase_next = PH_IPAD;
                        end
                        else
                        begin
                            blk_next = blk_reg + BW'(1);
                        end
                    end
                    PH_IPAD:
                    begin
                        ipad_next  = sum;
                        hc_next    = pbkdf2_pkg::SHA_IV;
                        bc_next    = '0;
                        phase_next = PH_OPAD;
                        state_next = ST_LOAD;
                    end
                    PH_OPAD:
                    begin
                        opad_next  = sum;
                        hc_next    = ipad_reg;
                        v_next     = ipad_reg;
                        win_next   = pbkdf2_pkg::salt_block(salt_reg);
                        rc_next    = '0;
                        phase_next = PH_INNER;
                        state_next = ST_ROUND;
                    end
                    PH_INNER:
                    begin
                        hc_next    = opad_reg;
                        v_next     = opad_reg;
                        win_next   = pbkdf2_pkg::digest_block(sum);
                        rc_next    = '0;
                        phase_next = PH_OUTER;
                        state_next = ST_ROUND;
                    end
                    PH_OUTER:
                    begin
                        // Fold this U into the key and, if iterations remain, chain it into the next inner hash
                        acc_next   = first_reg ? sum : (acc_reg ^ sum);
                        first_next = 1'b0;
                        it_next    = it_inc;
                        if (it_inc >= count_eff)
                        begin
                            word_next  = '0;
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            hc_next    = ipad_reg;
                            v_next     = ipad_reg;
                            win_next   = pbkdf2_pkg::digest_block(sum);
                            rc_next    = '0;
                            phase_next = PH_INNER;
                            state_next = ST_ROUND;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_OUT:
            begin
                if (out_ready)
                begin
                    word_next = word_reg + 2'd1;
                    if (word_reg == pbkdf2_pkg::LAST_WORD_IDX)
                    begin
                        len_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            phase_reg    <= PH_KHASH;
            blk_reg      <= '0;
            bc_reg       <= '0;
            ld_valid_reg <= 1'b0;
            rc_reg       <= '0;
            len_reg      <= '0;
            ovf_reg      <= 1'b0;
            hashed_reg   <= 1'b0;
            first_reg    <= 1'b0;
            it_reg       <= '0;
            iter_reg     <= pbkdf2_pkg::COUNT_RESET;
            word_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            blk_reg      <= blk_next;
            bc_reg       <= bc_next;
            ld_valid_reg <= ld_valid_next;
            rc_reg       <= rc_next;
            len_reg      <= len_next;
            ovf_reg      <= ovf_next;
            hashed_reg   <= hashed_next;
            first_reg    <= first_next;
            it_reg       <= it_next;
            iter_reg     <= iter_next;
            word_reg     <= word_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        win_reg  <= win_next;
        v_reg    <= v_next;
        hc_reg   <= hc_next;
        dig_reg  <= dig_next;
        ipad_reg <= ipad_next;
        opad_reg <= opad_next;
        acc_reg  <= acc_next;
        salt_reg <= salt_next;
    end

    // Hold each key word until taken; all four share the overflow status
    always_comb
    begin
        out_data.key_word   = {acc_reg[{word_reg, 1'b0}], acc_reg[{word_reg, 1'b1}]};
        out_data.word_index = word_reg;
        out_data.last_word  = (word_reg == pbkdf2_pkg::LAST_WORD_IDX);
        out_data.status     = ovf_reg;
    end

endmodule

// ===== rtl/pbkdf2_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pbkdf2_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/pbkdf2_checker.sv =====
// Port-level checker for the key derivation block and its bind.
module pbkdf2_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input pbkdf2_pkg::out_t            out_data
);

    // Never take a request while key words are pending
    assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
        else $error("request accepted while key words pending");

    // Drop out of output after the final word and take requests again
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_data.last_word |=> !out_valid && in_ready)
        else $error("block not idle after final key word");

    // Flag the final word exactly at the last index
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.last_word == (out_data.word_index == pbkdf2_pkg::LAST_WORD_IDX))
        else $error("last_word disagrees with word_index");

    // Advance the word index by one per taken word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_word |=>
            out_valid && out_data.word_index == $past(out_data.word_index) + 2'd1)
        else $error("word index did not advance");

    // Hold a stalled word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled key word changed");

endmodule

bind pbkdf2_hmac_sha256_key_derive pbkdf2_checker u_pbkdf2_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
